[hw/rtl/sprite_keyframe_sequencer_unit_assert.svh]
// Assertion macros for the sprite keyframe sequencer unit
`ifndef SPRITE_KEYFRAME_SEQUENCER_UNIT_ASSERT_SVH
`define SPRITE_KEYFRAME_SEQUENCER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SKS_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define SKS_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m failed");
`else
`define SKS_ASSERT_IMPL(label, clk, rst, prop)
`define SKS_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

[hw/rtl/sks_pkg.sv]
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types and constants of the sprite keyframe sequencer.
// ----------------------------------------------------------------------------
package sks_pkg;
   localparam int MaxAnims  = 16;
   localparam int MaxFrames = 64;
   localparam int TimeBits  = 32;

   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_KEY   = 3'd1,
      CMD_HDR   = 3'd2,
      CMD_START = 3'd3,
      CMD_REP   = 3'd4,
      CMD_NOP5  = 3'd5,
      CMD_NOP6  = 3'd6,
      CMD_NOP7  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_ZERO  = 2'd1,
      FAULT_RANGE = 2'd2,
      FAULT_RSVD  = 2'd3
   } fault_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] now_ms;
      logic [3:0]  anim_sel;
      logic [5:0]  frame_sel;
      logic [31:0] key_time;
      logic [6:0]  frame_count;
      logic [3:0]  next_anim;
      logic        has_next;
      logic [15:0] repeat_value;
      logic        repeat_forever;
   } item_type;

   typedef struct packed {
      logic [3:0]  active_anim;
      logic [5:0]  frame_index;
      logic        frame_valid;
      logic [15:0] repeats_left;
      logic        repeats_unlimited;
      logic [1:0]  fault;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LEN, ST_LAST, ST_LASTW, ST_CHAIN, ST_CHK,
      ST_DIV, ST_REP, ST_SRCH, ST_SRCHW, ST_DONE
   } state_type;
endpackage

[hw/rtl/sks_front.sv]
// ----------------------------------------------------------------------------
// sks_front
// Accept request words and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module sks_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sks_pkg::item_type in_item,
   output logic              q_valid,
   input  logic              q_ready,
   output sks_pkg::item_type q_item
);
   import sks_pkg::*;

   item_type   slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = slot_ff[rd_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   // advance pointers and count
   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end

   // store the word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_item;
      end
   end
endmodule

[hw/rtl/sks_divider.sv]
// ----------------------------------------------------------------------------
// sks_divider
// Restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sks_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sks_pkg::TimeBits-1:0]  dividend,
   input  logic [sks_pkg::TimeBits-1:0]  divisor,
   output logic                          done,
   output logic [sks_pkg::TimeBits-1:0]  quotient,
   output logic [sks_pkg::TimeBits-1:0]  remainder
);
   import sks_pkg::*;
   localparam int CntBits = $clog2(TimeBits + 1);

   logic [TimeBits-1:0] q_ff, q_in, d_ff, d_in;
   logic [TimeBits:0]   r_ff, r_in, trial;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;

   assign trial     = {r_ff[TimeBits-1:0], q_ff[TimeBits-1]} - {1'b0, d_ff};
   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff[TimeBits-1:0];

   // shift one bit and subtract where it fits
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = CntBits'(TimeBits); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[TimeBits]) begin
            r_in = {r_ff[TimeBits-1:0], q_ff[TimeBits-1]};
            q_in = {q_ff[TimeBits-2:0], 1'b0};
         end else begin
            r_in = trial;
            q_in = {q_ff[TimeBits-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
   end
endmodule

[hw/rtl/sks_back.sv]
// ----------------------------------------------------------------------------
// sks_back
// Carry out queued words: table writes, start, repeats, tick sequencing.
// ----------------------------------------------------------------------------
module sks_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                update_enable,
   input  logic                q_valid,
   output logic                q_ready,
   input  sks_pkg::item_type   q_item,
   output logic                out_valid,
   input  logic                out_ready,
   output sks_pkg::result_type out_result,
   output logic                busy
);
   import sks_pkg::*;

   // key time memory, one read port registered
   logic [31:0] key_mem [MaxAnims*MaxFrames];
   logic [9:0]  kaddr;
   logic        kwe;
   logic [31:0] kdata_ff;

   // header tables, small register arrays
   logic [6:0]  len_ff   [MaxAnims];
   logic [3:0]  fol_ff   [MaxAnims];
   logic        folv_ff  [MaxAnims];
   logic [15:0] drep_ff  [MaxAnims];
   logic        dfor_ff  [MaxAnims];

   state_type   st_ff, st_in;
   item_type    it_ff;
   logic [3:0]  anim_ff, anim_in;
   logic [31:0] start_ff, start_in;
   logic [15:0] rep_ff, rep_in;
   logic        unl_ff, unl_in;
   logic [5:0]  shown_ff, shown_in;
   logic        sv_ff, sv_in;
   logic [1:0]  fault_ff, fault_in;
   logic [6:0]  n_ff, n_in;
   logic [31:0] last_ff, last_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] prev_ff, prev_in;
   logic [5:0]  f_ff, f_in;
   logic        ov_ff, ov_in;
   logic        chain_ff, chain_in;
   logic        div_start, div_done;
   logic [31:0] div_q, div_r;
   logic [6:0]  cur_len;
   logic        take;

   assign cur_len    = len_ff[anim_ff];
   assign q_ready    = (st_ff == ST_IDLE) && !ov_ff;
   assign take       = q_valid && q_ready;
   assign out_valid  = ov_ff;
   assign busy       = (st_ff != ST_IDLE) || ov_ff;
   assign out_result = '{active_anim: anim_ff, frame_index: shown_ff, frame_valid: sv_ff,
                         repeats_left: rep_ff, repeats_unlimited: unl_ff, fault: fault_ff};

   sks_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(it_ff.now_ms - start_ff), .divisor(last_ff),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   // memory address per state
   always_comb begin
      kaddr = {anim_ff, 6'(n_ff - 7'd1)};
      kwe   = 1'b0;
      if (st_ff == ST_IDLE) begin
         kaddr = {q_item.anim_sel, q_item.frame_sel};
         kwe   = take && (cmd_type'(q_item.cmd) == CMD_KEY);
      end else if (st_ff == ST_SRCH || st_ff == ST_SRCHW) begin
         kaddr = {anim_ff, f_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (kwe) begin
         key_mem[kaddr] <= q_item.key_time;
      end
      kdata_ff <= key_mem[kaddr];
   end

   // header writes
   always_ff @(posedge clock) begin
      if (take && cmd_type'(q_item.cmd) == CMD_HDR) begin
         len_ff[q_item.anim_sel]  <= q_item.frame_count;
         fol_ff[q_item.anim_sel]  <= q_item.next_anim;
         folv_ff[q_item.anim_sel] <= q_item.has_next;
         drep_ff[q_item.anim_sel] <= q_item.repeat_value;
         dfor_ff[q_item.anim_sel] <= q_item.repeat_forever;
      end
      if (take) begin
         it_ff <= q_item;
      end
   end

   // next state and datapath
   always_comb begin
      st_in = st_ff; anim_in = anim_ff; start_in = start_ff; rep_in = rep_ff;
      unl_in = unl_ff; shown_in = shown_ff; sv_in = sv_ff; fault_in = fault_ff;
      n_in = n_ff; last_in = last_ff; rem_in = rem_ff; prev_in = prev_ff;
      f_in = f_ff; ov_in = ov_ff; chain_in = chain_ff; div_start = 1'b0;
      if (ov_ff && out_ready) begin
         ov_in = 1'b0;
      end
      case (st_ff)
         ST_IDLE: begin
            if (take) begin
               fault_in = FAULT_NONE;
               case (cmd_type'(q_item.cmd))
                  CMD_TICK: begin
                     if (update_enable) st_in = ST_LEN;
                     else ov_in = 1'b1;
                  end
                  CMD_START: begin
                     anim_in = q_item.anim_sel; shown_in = '0; sv_in = 1'b1;
                     start_in = q_item.now_ms; ov_in = 1'b1;
                  end
                  CMD_REP: begin
                     unl_in = q_item.repeat_forever;
                     rep_in = q_item.repeat_forever ? 16'd0 : q_item.repeat_value;
                     ov_in = 1'b1;
                  end
                  default: ov_in = 1'b1;
               endcase
            end
         end
         ST_LEN: begin
            chain_in = 1'b0;
            if (cur_len == 7'd0 || cur_len > 7'(MaxFrames)) begin
               fault_in = FAULT_RANGE; st_in = ST_DONE;
            end else begin
               n_in = cur_len; st_in = ST_LAST;
            end
         end
         ST_LAST: st_in = ST_LASTW;
         ST_LASTW: begin
            last_in = kdata_ff;
            // chain at most once per tick
            if (!chain_ff && !unl_ff && rep_ff == 16'd0) begin
               if (!folv_ff[anim_ff]) begin
                  shown_in = 6'(n_ff - 7'd1); sv_in = 1'b1; st_in = ST_DONE;
               end else if (len_ff[fol_ff[anim_ff]] == 7'd0 ||
                            len_ff[fol_ff[anim_ff]] > 7'(MaxFrames)) begin
                  fault_in = FAULT_RANGE; st_in = ST_DONE;
               end else begin
                  st_in = ST_CHAIN;
               end
            end else begin
               st_in = ST_CHK;
            end
         end
         ST_CHAIN: begin
            anim_in = fol_ff[anim_ff]; shown_in = '0; sv_in = 1'b1;
            start_in = it_ff.now_ms;
            unl_in = dfor_ff[fol_ff[anim_ff]];
            rep_in = dfor_ff[fol_ff[anim_ff]] ? 16'd0 : drep_ff[fol_ff[anim_ff]];
            n_in = len_ff[fol_ff[anim_ff]];
            chain_in = 1'b1;
            st_in = ST_LAST;
         end
         ST_CHK: begin
            if (last_ff == 32'd0) begin
               fault_in = FAULT_ZERO; st_in = ST_DONE;
            end else begin
               div_start = 1'b1; st_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rem_in = div_r;
               if (!unl_ff && div_q != 32'd0) begin
                  rep_in = (div_q >= {16'd0, rep_ff}) ? 16'd0 : rep_ff - div_q[15:0];
                  start_in = it_ff.now_ms - div_r;
               end
               st_in = ST_REP;
            end
         end
         ST_REP: begin
            if (unl_ff || rep_ff != 16'd0) begin
               shown_in = '0; sv_in = 1'b0; f_in = '0; st_in = ST_SRCH;
               if (n_ff == 7'd1) st_in = ST_DONE;
            end else begin
               st_in = ST_DONE;
            end
         end
         ST_SRCH: st_in = ST_SRCHW;
         ST_SRCHW: begin
            // kdata holds key f; compare pair (f-1, f)
            if (f_ff != 6'd0 && prev_ff <= rem_ff && rem_ff <= kdata_ff) begin
               shown_in = f_ff - 6'd1; sv_in = 1'b1; st_in = ST_DONE;
            end else if (7'(f_ff) + 7'd1 >= n_ff) begin
               st_in = ST_DONE;
            end else begin
               prev_in = kdata_ff; f_in = f_ff + 6'd1; st_in = ST_SRCH;
            end
         end
         ST_DONE: begin
            ov_in = 1'b1; st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; anim_ff <= '0; start_ff <= '0; rep_ff <= '0;
         unl_ff <= 1'b1; shown_ff <= '0; sv_ff <= 1'b1; fault_ff <= FAULT_NONE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; anim_ff <= anim_in; start_ff <= start_in; rep_ff <= rep_in;
         unl_ff <= unl_in; shown_ff <= shown_in; sv_ff <= sv_in; fault_ff <= fault_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; last_ff <= last_in; rem_ff <= rem_in;
      prev_ff <= prev_in; f_ff <= f_in; chain_ff <= chain_in;
   end
endmodule

[hw/rtl/sprite_keyframe_sequencer_unit.sv]
// A tick, once the sequencer has taken it, checks the frame count, reads
// the last key time, runs a 32-bit serial divide and searches the frames
// through the key time memory's single read port, a key read then a compare
// per frame, and may first chain to the following animation. Other commands
// put their result out in the cycle after the sequencer takes them. Up to two
// words queue ahead of the sequencer, and one result waits in the output
// register, which holds the next word back.
// ----------------------------------------------------------------------------
// sprite_keyframe_sequencer_unit
// Sprite animation sequencer: key time tables, chaining and frame search.
// ----------------------------------------------------------------------------
`include "sprite_keyframe_sequencer_unit_assert.svh"
module sprite_keyframe_sequencer_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[2:0] now_ms[34:3] anim_sel[38:35] frame_sel[44:39] key_time[76:45]
   // frame_count[83:77] next_anim[87:84] has_next[88] repeat_value[104:89]
   // repeat_forever[105], zero fill to 111
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // active_anim[3:0] frame_index[9:4] frame_valid[10] repeats_left[26:11]
   // repeats_unlimited[27] fault[29:28], zero fill to 31
   output logic [31:0]  rsp_tdata
);
   import sks_pkg::*;

   logic       en_ff;
   logic       q_valid, q_ready, busy;
   item_type   in_item, q_item;
   result_type res;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) en_ff <= 1'b1;
      else if (csr_valid) en_ff <= csr_data;
   end

   // unpack request word
   assign in_item = '{cmd: req_tdata[2:0], now_ms: req_tdata[34:3],
                      anim_sel: req_tdata[38:35], frame_sel: req_tdata[44:39],
                      key_time: req_tdata[76:45], frame_count: req_tdata[83:77],
                      next_anim: req_tdata[87:84], has_next: req_tdata[88],
                      repeat_value: req_tdata[104:89], repeat_forever: req_tdata[105]};

   sks_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   sks_back u_back (
      .clock(clock), .reset(reset), .update_enable(en_ff), .q_valid(q_valid),
      .q_ready(q_ready), .q_item(q_item), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .out_result(res), .busy(busy)
   );

   assign rsp_tdata = {2'b00, res.fault, res.repeats_unlimited, res.repeats_left,
                       res.frame_valid, res.frame_index, res.active_anim};

   `SKS_ASSERT_NEVER(a_fault_code, clock, reset, rsp_tvalid && rsp_tdata[29:28] == 2'd3)
   `SKS_ASSERT_IMPL(a_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
   `SKS_ASSERT_NEVER(a_busy, clock, reset, rsp_tvalid && !busy)
endmodule

[tb/sv/sprite_keyframe_sequencer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_keyframe_sequencer_unit_tb
// Self-checking bench for the sprite keyframe sequencer. Command words are
// streamed in with random gaps, and every result word is checked against an
// in-bench playback predictor. The animation tables are filled before any
// tick reads them. Directed words cover the special cases. Random sequences
// of header, key, start, repeat and tick words follow, mixed with noise.
// ----------------------------------------------------------------------------
module sprite_keyframe_sequencer_unit_tb;
   import sks_pkg::*;

   localparam int CycleLimit = 3000000;
   localparam int TargetWords = 1850;

   logic         clock;
   logic         reset;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;

   sprite_keyframe_sequencer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Predictor copy of the tables and playback state
   logic [31:0] key_tab [MaxAnims][MaxFrames];
   bit          key_known [MaxAnims][MaxFrames];
   logic [6:0]  len_tab [MaxAnims];
   logic [3:0]  follow_tab [MaxAnims];
   logic        follow_ok_tab [MaxAnims];
   logic [15:0] dflt_rep_tab [MaxAnims];
   logic        dflt_inf_tab [MaxAnims];
   logic [3:0]  play_anim;
   logic [31:0] play_start;
   logic [15:0] play_reps;
   logic        play_inf;
   logic [5:0]  play_frame;
   logic        play_frame_ok;
   logic        update_en;

   result_type pending_results[$];
   int         mismatches;
   int         words_sent;
   int         results_seen;
   bit         stall_free;
   logic [31:0] clock_ms;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   initial begin
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic bit length_ok(logic [3:0] a);
      return len_tab[a] != 0 && len_tab[a] <= MaxFrames;
   endfunction

   // Advance playback for one tick, return fault code
   function automatic fault_type advance_playback(logic [31:0] now);
      logic [3:0]  a;
      logic [6:0]  n;
      logic [31:0] last, elapsed, laps, rem;
      a = play_anim;
      if (!length_ok(a)) return FAULT_RANGE;
      n = len_tab[a];
      last = key_tab[a][n - 1];
      if (!play_inf && play_reps == 0) begin
         if (!follow_ok_tab[a]) begin
            play_frame = 6'(n - 1);
            play_frame_ok = 1'b1;
            return FAULT_NONE;
         end
         if (!length_ok(follow_tab[a])) return FAULT_RANGE;
         a = follow_tab[a];
         play_anim = a;
         play_frame = '0;
         play_frame_ok = 1'b1;
         play_start = now;
         play_inf = dflt_inf_tab[a];
         play_reps = dflt_inf_tab[a] ? 16'd0 : dflt_rep_tab[a];
         n = len_tab[a];
         last = key_tab[a][n - 1];
      end
      if (last == 0) return FAULT_ZERO;
      elapsed = now - play_start;
      laps = elapsed / last;
      rem = elapsed % last;
      if (!play_inf && laps > 0) begin
         play_reps = (laps >= {16'd0, play_reps}) ? 16'd0 : play_reps - 16'(laps);
         play_start = now - rem;
      end
      if (play_inf || play_reps != 0) begin
         play_frame = '0;
         play_frame_ok = 1'b0;
         for (int f = 0; f + 1 < n; f++) begin
            if (key_tab[a][f] <= rem && rem <= key_tab[a][f + 1]) begin
               play_frame = 6'(f);
               play_frame_ok = 1'b1;
               break;
            end
         end
      end
      return FAULT_NONE;
   endfunction

   // Apply one command word to the predictor and return the expected result
   function automatic result_type apply_word(item_type it);
      result_type r;
      fault_type  flt;
      flt = FAULT_NONE;
      case (cmd_type'(it.cmd))
         CMD_TICK: if (update_en) flt = advance_playback(it.now_ms);
         CMD_KEY: begin
            key_tab[it.anim_sel][it.frame_sel] = it.key_time;
            key_known[it.anim_sel][it.frame_sel] = 1'b1;
         end
         CMD_HDR: begin
            len_tab[it.anim_sel] = it.frame_count;
            follow_tab[it.anim_sel] = it.next_anim;
            follow_ok_tab[it.anim_sel] = it.has_next;
            dflt_rep_tab[it.anim_sel] = it.repeat_value;
            dflt_inf_tab[it.anim_sel] = it.repeat_forever;
         end
         CMD_START: begin
            play_anim = it.anim_sel;
            play_frame = '0;
            play_frame_ok = 1'b1;
            play_start = it.now_ms;
         end
         CMD_REP: begin
            play_inf = it.repeat_forever;
            play_reps = it.repeat_forever ? 16'd0 : it.repeat_value;
         end
         default: ;
      endcase
      r.active_anim = play_anim;
      r.frame_index = play_frame;
      r.frame_valid = play_frame_ok;
      r.repeats_left = play_reps;
      r.repeats_unlimited = play_inf;
      r.fault = flt;
      return r;
   endfunction

   function automatic int draw_wait();
      if (stall_free) return 0;
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
   endfunction

   // Send one command word; called and returns at a falling edge
   task automatic send_word(item_type it);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {6'd0, it.repeat_forever, it.repeat_value, it.has_next, it.next_anim,
                   it.frame_count, it.key_time, it.frame_sel, it.anim_sel, it.now_ms,
                   it.cmd};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(apply_word(it));
      words_sent++;
      @(negedge clock);
   endtask

   function automatic item_type make_word(cmd_type c);
      item_type it;
      it = '0;
      it.cmd = c;
      return it;
   endfunction

   task automatic send_key(int a, int f, logic [31:0] t);
      item_type it;
      it = make_word(CMD_KEY);
      it.anim_sel = 4'(a);
      it.frame_sel = 6'(f);
      it.key_time = t;
      it.now_ms = $urandom;
      send_word(it);
   endtask

   // Fill any unwritten key times below the frame count, a random step apart plus jitter
   task automatic fill_keys(int a, int n);
      int span;
      span = $urandom_range(1, 200);
      for (int f = 0; f < n && f < MaxFrames; f++)
         if (!key_known[a][f]) send_key(a, f, f * span + ((f == 0) ? 0 : $urandom_range(0, 9)));
   endtask

   task automatic send_header(int a, int n, int nxt, bit hn, int rv, bit rf);
      item_type it;
      if (n >= 1 && n <= MaxFrames) fill_keys(a, n);
      it = make_word(CMD_HDR);
      it.anim_sel = 4'(a);
      it.frame_count = 7'(n);
      it.next_anim = 4'(nxt);
      it.has_next = hn;
      it.repeat_value = 16'(rv);
      it.repeat_forever = rf;
      send_word(it);
   endtask

   task automatic send_start(int a, logic [31:0] now);
      item_type it;
      it = make_word(CMD_START);
      it.anim_sel = 4'(a);
      it.now_ms = now;
      clock_ms = now;
      send_word(it);
   endtask

   task automatic send_repeats(int rv, bit rf);
      item_type it;
      it = make_word(CMD_REP);
      it.repeat_value = 16'(rv);
      it.repeat_forever = rf;
      send_word(it);
   endtask

   task automatic send_tick(logic [31:0] now);
      item_type it;
      it = make_word(CMD_TICK);
      it.now_ms = now;
      clock_ms = now;
      send_word(it);
   endtask

   // Hold until every result is back and the sequencer has settled
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_update_enable(bit v);
      drain();
      csr_data = v;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      update_en = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Result checker
   initial begin
      result_type got, want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.active_anim = rsp_tdata[3:0];
            got.frame_index = rsp_tdata[9:4];
            got.frame_valid = rsp_tdata[10];
            got.repeats_left = rsp_tdata[26:11];
            got.repeats_unlimited = rsp_tdata[27];
            got.fault = rsp_tdata[29:28];
            results_seen++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word %h", rsp_tdata);
            end else begin
               want = pending_results.pop_front();
               if (got.active_anim !== want.active_anim || got.frame_index !== want.frame_index
                   || got.frame_valid !== want.frame_valid
                   || got.repeats_left !== want.repeats_left
                   || got.repeats_unlimited !== want.repeats_unlimited
                   || got.fault !== want.fault) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected anim %0d frame %0d ok %0b reps %0d inf %0b fault %0d, got anim %0d frame %0d ok %0b reps %0d inf %0b fault %0d",
                              results_seen, want.active_anim, want.frame_index, want.frame_valid,
                              want.repeats_left, want.repeats_unlimited, want.fault,
                              got.active_anim, got.frame_index, got.frame_valid,
                              got.repeats_left, got.repeats_unlimited, got.fault);
               end
            end
         end
      end
   end

   // Result back-pressure
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Fill every header and the key times below each frame count
   task automatic test_table_setup();
      for (int a = 0; a < MaxAnims; a++)
         send_header(a, (a % 6) + 2, (a + 1) % MaxAnims, (a % 3) != 0, a % 4, a == 5);
   endtask

   // Field extremes and named special cases
   task automatic test_directed();
      item_type it;
      send_key(15, 63, 32'hFFFF_FFFF);
      send_header(14, 64, 15, 1'b1, 16'hFFFF, 1'b0);
      send_start(14, 32'hFFFF_FF00);
      send_repeats(0, 1'b1);
      send_tick(32'h0000_1000);
      // chaining once repeats run out
      send_start(1, 32'd0);
      send_repeats(2, 1'b0);
      send_tick(32'd50);
      send_tick(32'd250);
      send_tick(32'd10000);
      // bad frame count, both sides of the range
      send_header(3, 0, 0, 1'b0, 0, 1'b0);
      send_start(3, 32'd0);
      send_tick(32'd5);
      send_header(3, 127, 15, 1'b1, 16'hFFFF, 1'b1);
      send_tick(32'hFFFF_FFFF);
      send_header(3, 5, 4, 1'b1, 1, 1'b0);
      // zero last key time
      send_key(4, 5, 32'd0);
      send_start(4, 32'd0);
      send_tick(32'd30);
      send_key(4, 5, 32'd500);
      // no interval found
      send_key(6, 0, 32'd50);
      send_start(6, 32'd0);
      send_repeats(0, 1'b1);
      send_tick(32'd10);
      send_key(6, 0, 32'd0);
      // repeats used up without a following animation: hold last frame
      send_start(0, 32'd100);
      send_repeats(0, 1'b0);
      send_tick(32'd120);
      send_repeats(16'hFFFF, 1'b0);
      // unused commands
      for (int c = 5; c < 8; c++) begin
         it = item_type'(106'({$urandom, $urandom, $urandom, $urandom}));
         it.cmd = 3'(c);
         send_word(it);
      end
   endtask

   // Ticks with updates switched off report state unchanged
   task automatic test_update_disabled();
      write_update_enable(1'b0);
      send_start(2, 32'd0);
      for (int i = 0; i < 8; i++) send_tick($urandom);
      send_repeats(3, 1'b0);
      send_tick(32'hFFFF_FFFF);
      write_update_enable(1'b1);
   endtask

   // One well-formed playback sequence with random content
   task automatic play_sequence();
      int a, n, ticks, span;
      logic [31:0] last;
      a = $urandom_range(0, MaxAnims - 1);
      if ($urandom_range(0, 2) == 0) begin
         case ($urandom_range(0, 9))
            0: n = MaxFrames;
            1: n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MaxFrames + 1, 127);
            default: n = $urandom_range(1, 8);
         endcase
         send_header(a, n, $urandom_range(0, MaxAnims - 1), $urandom_range(0, 1),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 4),
                     $urandom_range(0, 5) == 0);
      end
      // rewrite some key times of this animation
      n = len_tab[a];
      if (n >= 1 && n <= MaxFrames && $urandom_range(0, 2) == 0) begin
         span = $urandom_range(1, 300);
         for (int f = 0; f < n && f < 10; f++)
            case ($urandom_range(0, 11))
               0: send_key(a, f, $urandom);
               1: send_key(a, f, 32'd0);
               default: send_key(a, f, f * span + ((f == 0) ? 0 : $urandom_range(0, 20)));
            endcase
      end
      send_start(a, ($urandom_range(0, 5) == 0) ? $urandom : clock_ms);
      case ($urandom_range(0, 5))
         0: send_repeats(0, 1'b1);
         1: send_repeats($urandom_range(0, 65535), $urandom_range(0, 1));
         default: send_repeats($urandom_range(0, 5), 1'b0);
      endcase
      ticks = $urandom_range(2, 12);
      for (int i = 0; i < ticks; i++) begin
         n = len_tab[play_anim];
         last = (n >= 1 && n <= MaxFrames) ? key_tab[play_anim][n - 1] : 32'd100;
         if (last > 32'd100000 || last == 0) last = 32'd1000;
         if ($urandom_range(0, 15) == 0) send_tick($urandom);
         else send_tick(clock_ms + $urandom_range(0, 2 * last + 5));
      end
   endtask

   // Random noise word that keeps every table read defined
   task automatic send_noise();
      item_type it;
      it = item_type'(106'({$urandom, $urandom, $urandom, $urandom}));
      if (it.cmd == CMD_HDR && it.frame_count >= 1 && it.frame_count <= MaxFrames)
         fill_keys(it.anim_sel, it.frame_count);
      send_word(it);
   endtask

   task automatic test_random();
      int phase;
      phase = 0;
      while (words_sent < TargetWords) begin
         if ($urandom_range(0, 4) == 0) send_noise();
         else play_sequence();
         // move between idling and back-to-back stretches
         if ($urandom_range(0, 30) == 0) stall_free = ~stall_free;
         if (words_sent > (phase + 1) * 450) begin
            phase++;
            write_update_enable(phase % 2);
         end
      end
      stall_free = 1'b0;
      write_update_enable(1'b1);
      // several random noise words with updates off, then updates on again
      write_update_enable(1'b0);
      for (int i = 0; i < 10; i++) send_noise();
      write_update_enable(1'b1);
   endtask

   // Main sequence
   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      mismatches = 0;
      words_sent = 0;
      results_seen = 0;
      stall_free = 1'b0;
      clock_ms = '0;
      update_en = 1'b1;
      play_anim = '0;
      play_start = '0;
      play_reps = '0;
      play_inf = 1'b1;
      play_frame = '0;
      play_frame_ok = 1'b1;
      for (int a = 0; a < MaxAnims; a++)
         for (int f = 0; f < MaxFrames; f++) key_known[a][f] = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_update_enable(1'b1);
      test_table_setup();
      test_directed();
      test_update_disabled();
      write_update_enable(1'b0);
      write_update_enable(1'b1);
      test_random();
      drain();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
